>>> rtl/core/asrf_pkg.sv
package asrf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FILL_W = 10;
	localparam int MARK_W = 11;
	localparam int FRAC_W = 28;
	localparam int RATIO_W = 29;
	localparam int PHASE_W = 30;
	localparam int IPART_W = PHASE_W - FRAC_W;
	localparam int CFG_INDEX_W = 2;
	localparam int OUT_TDATA_W = 56;

	localparam logic [RATIO_W-1:0] RATIO_ONE = 29'd268435456;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 29'd281857228;
	localparam logic [RATIO_W-1:0] RATIO_MIN = 29'd255013683;

	// Division by 200 as a multiplication by a rounded-up reciprocal, exact for 29-bit values.
	localparam int DIV_MUL_W = 30;
	localparam logic [DIV_MUL_W-1:0] RATIO_DIV_MUL = 30'd687194768;
	localparam int RATIO_DIV_SHIFT = 37;

	localparam logic [MARK_W-1:0] LOW_MARK_RST = 11'd256;
	localparam logic [MARK_W-1:0] HIGH_MARK_RST = 11'd768;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_MODE = 2'd0,
		REG_LOW_MARK    = 2'd1,
		REG_HIGH_MARK   = 2'd2
	} asrf_reg_t;

	typedef struct packed {
		logic                done;
		logic                rd_ok;
		logic                mode;
		logic [FRAC_W-1:0]   frac;
		logic [FILL_W-1:0]   fill;
		logic [RATIO_W-1:0]  ratio;
	} asrf_info_t;

endpackage

>>> rtl/core/asrf_ram.sv
module asrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> rtl/core/asrf_ctrl.sv
module asrf_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic                                op,
	input  logic [asrf_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                last,
	input  logic                                mode,
	input  logic [asrf_pkg::MARK_W-1:0]         low_mark,
	input  logic [asrf_pkg::MARK_W-1:0]         high_mark,
	output logic                                ram_we,
	output logic [$clog2(DEPTH)-1:0]            ram_waddr,
	output logic [asrf_pkg::SAMPLE_W-1:0]       ram_wdata,
	output logic [$clog2(DEPTH)-1:0]            ram_raddr_a,
	output logic [$clog2(DEPTH)-1:0]            ram_raddr_b,
	output asrf_pkg::asrf_info_t                info
);

	import asrf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CMP_W = (PTR_W > MARK_W) ? PTR_W : MARK_W;
	localparam int CNT_W = PTR_W + 1;
	localparam int MULP_W = RATIO_W + DIV_MUL_W;

	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [PHASE_W-1:0] phase_q;
	logic [RATIO_W-1:0] ratio_q;

	logic [PTR_W-1:0]   count;
	logic               full;
	logic [IPART_W-1:0] ipart;
	logic [FRAC_W-1:0]  frac;
	logic [PTR_W-1:0]   rd;
	logic               rd_ok;
	logic               wr_ok;
	logic [PTR_W-1:0]   count_nx;
	logic [MULP_W-1:0]  div_prod;
	logic [RATIO_W-1:0] ratio_step;
	logic [RATIO_W:0]   ratio_up_raw;
	logic [RATIO_W-1:0] ratio_up;
	logic [RATIO_W-1:0] ratio_dn_raw;
	logic [RATIO_W-1:0] ratio_dn;
	logic               raise;
	logic               lower;
	logic [RATIO_W-1:0] ratio_nx;

	always_comb begin
		count = wp_q - rp_q;
		full = &count;
		ipart = phase_q[PHASE_W-1:FRAC_W];
		frac = phase_q[FRAC_W-1:0];
		rd = rp_q + PTR_W'(ipart);
		rd_ok = op && ({1'b0, count} >= (CNT_W'(ipart) + CNT_W'(2)));
		wr_ok = !op && !full;
		if (wr_ok) begin
			count_nx = count + PTR_W'(1);
		end else if (rd_ok) begin
			count_nx = count - PTR_W'(ipart);
		end else begin
			count_nx = count;
		end

		div_prod = MULP_W'(ratio_q) * MULP_W'(RATIO_DIV_MUL);
		ratio_step = RATIO_W'(div_prod[MULP_W-1:RATIO_DIV_SHIFT]);
		ratio_up_raw = {1'b0, ratio_q} + {1'b0, ratio_step};
		ratio_up = (ratio_up_raw > {1'b0, RATIO_MAX}) ? RATIO_MAX : ratio_up_raw[RATIO_W-1:0];
		ratio_dn_raw = ratio_q - ratio_step;
		ratio_dn = (ratio_dn_raw < RATIO_MIN) ? RATIO_MIN : ratio_dn_raw;

		raise = last && !op && (CMP_W'(count_nx) > CMP_W'(high_mark));
		lower = last && op && (CMP_W'(count_nx) < CMP_W'(low_mark));
		if (raise) begin
			ratio_nx = ratio_up;
		end else if (lower) begin
			ratio_nx = ratio_dn;
		end else begin
			ratio_nx = ratio_q;
		end
	end

	always_comb begin
		ram_we = fire && wr_ok;
		ram_waddr = wp_q;
		ram_wdata = mode ? sample : {{(SAMPLE_W-8){1'b0}}, sample[7:0]};
		ram_raddr_a = rd;
		ram_raddr_b = rd + PTR_W'(1);
		info.done = wr_ok || rd_ok;
		info.rd_ok = rd_ok;
		info.mode = mode;
		info.frac = frac;
		info.fill = FILL_W'(count_nx);
		info.ratio = ratio_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			phase_q <= '0;
			ratio_q <= RATIO_ONE;
		end else if (fire) begin
			if (wr_ok) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (rd_ok) begin
				rp_q <= rd;
				phase_q <= PHASE_W'(frac) + PHASE_W'(ratio_q);
			end
			ratio_q <= ratio_nx;
		end
	end

endmodule

>>> rtl/core/asrf_interp.sv
module asrf_interp (
	input  logic                          clk,
	input  logic                          adv2,
	input  logic                          adv3,
	input  logic                          adv_out,
	input  asrf_pkg::asrf_info_t          info,
	input  logic [asrf_pkg::SAMPLE_W-1:0] rdata_a,
	input  logic [asrf_pkg::SAMPLE_W-1:0] rdata_b,
	output logic                          done_res,
	output logic [asrf_pkg::SAMPLE_W-1:0] sample_out,
	output logic [asrf_pkg::FILL_W-1:0]   fill_count,
	output logic [asrf_pkg::RATIO_W-1:0]  ratio_now
);

	import asrf_pkg::*;

	localparam int VAL_W = SAMPLE_W + 1;
	localparam int DIFF_W = SAMPLE_W + 2;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;
	localparam int SUM_W = PROD_W - FRAC_W;

	asrf_info_t               info_s2;
	asrf_info_t               info_s3;
	logic signed [VAL_W-1:0]  a_val;
	logic signed [VAL_W-1:0]  b_val;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [VAL_W-1:0]  a_s3;
	logic signed [SUM_W-1:0]  delta;
	logic signed [SUM_W-1:0]  blend;
	logic [SAMPLE_W-1:0]      sample_nx;

	always_comb begin
		if (info_s2.mode) begin
			a_val = VAL_W'($signed(rdata_a));
			b_val = VAL_W'($signed(rdata_b));
		end else begin
			a_val = $signed({{(VAL_W-8){1'b0}}, rdata_a[7:0]});
			b_val = $signed({{(VAL_W-8){1'b0}}, rdata_b[7:0]});
		end
		diff = DIFF_W'(b_val) - DIFF_W'(a_val);
		prod = PROD_W'(diff) * PROD_W'($signed({1'b0, info_s2.frac}));
	end

	always_comb begin
		delta = prod_s3[PROD_W-1:FRAC_W];
		blend = SUM_W'(a_s3) + delta;
		if (!info_s3.rd_ok) begin
			sample_nx = '0;
		end else if (info_s3.mode) begin
			sample_nx = blend[SAMPLE_W-1:0];
		end else begin
			sample_nx = {{(SAMPLE_W-8){1'b0}}, blend[7:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			info_s2 <= info;
		end
		if (adv3) begin
			info_s3 <= info_s2;
			prod_s3 <= prod;
			a_s3 <= a_val;
		end
		if (adv_out) begin
			done_res <= info_s3.done;
			sample_out <= sample_nx;
			fill_count <= info_s3.fill;
			ratio_now <= info_s3.ratio;
		end
	end

endmodule

>>> rtl/core/adaptive_resampling_sample_fifo_unit.sv
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tuser operation, tdata sample_in, tlast end
// m_axis   out        m_axis_tvalid / m_axis_tready  tuser done_res, tdata sample/fill/ratio
// cfg      in         cfg_valid / cfg_ready          cfg_index register, cfg_data value
//
// One transaction is accepted per cycle while the output is not stalled; its result passes the
// s1, s2 and s3 stages and the output register before it is offered. Pointers, phase and ratio
// update as a transaction leaves s1; the store is a two-read-port RAM with a registered read.
// Reset zeroes pointers, phase, valid bits; presets ratio and registers; the store is not cleared.
// Each stage holds while the one after it is full and stalled, so bubbles close up under stall.
module adaptive_resampling_sample_fifo_unit #(
	parameter int DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [asrf_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample_in
	input  logic                                 s_axis_tuser,  // [0] operation
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [15:0] sample_out, [25:16] fill_count, [54:26] ratio_now, [55] zero
	output logic [asrf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tuser,  // [0] done_res
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [asrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [asrf_pkg::MARK_W-1:0]          cfg_data
);

	import asrf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic                mode_q;
	logic [MARK_W-1:0]   low_mark_q;
	logic [MARK_W-1:0]   high_mark_q;

	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic                m_valid_q;
	logic                op_s1;
	logic                last_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic                adv_out;
	logic                adv3;
	logic                adv2;
	logic                adv1;
	logic                fire;

	logic                ram_we;
	logic [PTR_W-1:0]    ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [PTR_W-1:0]    ram_raddr_a;
	logic [PTR_W-1:0]    ram_raddr_b;
	logic [SAMPLE_W-1:0] ram_rdata_a;
	logic [SAMPLE_W-1:0] ram_rdata_b;
	asrf_info_t          info;

	logic                done_res;
	logic [SAMPLE_W-1:0] sample_out;
	logic [FILL_W-1:0]   fill_count;
	logic [RATIO_W-1:0]  ratio_now;

	always_comb begin
		adv_out = !m_valid_q || m_axis_tready;
		adv3 = !v_s3 || adv_out;
		adv2 = !v_s2 || adv3;
		adv1 = !v_s1 || adv2;
		fire = v_s1 && adv2;
		s_axis_tready = adv1;
		cfg_ready = 1'b1;
		m_axis_tvalid = m_valid_q;
		m_axis_tuser = done_res;
		m_axis_tdata = OUT_TDATA_W'({ratio_now, fill_count, sample_out});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			low_mark_q <= LOW_MARK_RST;
			high_mark_q <= HIGH_MARK_RST;
		end else if (cfg_valid) begin
			case (asrf_reg_t'(cfg_index))
				REG_SAMPLE_MODE: mode_q <= cfg_data[0];
				REG_LOW_MARK:    low_mark_q <= cfg_data;
				REG_HIGH_MARK:   high_mark_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				m_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && adv1) begin
			op_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
			sample_s1 <= s_axis_tdata;
		end
	end

	asrf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.sample     (sample_s1),
		.last       (last_s1),
		.mode       (mode_q),
		.low_mark   (low_mark_q),
		.high_mark  (high_mark_q),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr_a(ram_raddr_a),
		.ram_raddr_b(ram_raddr_b),
		.info       (info)
	);

	asrf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (adv2),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	asrf_interp u_interp (
		.clk       (clk),
		.adv2      (adv2),
		.adv3      (adv3),
		.adv_out   (adv_out),
		.info      (info),
		.rdata_a   (ram_rdata_a),
		.rdata_b   (ram_rdata_b),
		.done_res  (done_res),
		.sample_out(sample_out),
		.fill_count(fill_count),
		.ratio_now (ratio_now)
	);

endmodule

>>> tb/asrf_tb_pkg.sv
package asrf_tb_pkg;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic {
		MODE_BYTE = 1'b0,
		MODE_WORD = 1'b1
	} smp_mode_t;

	// Register index with no register behind it; writes to it must have no effect.
	localparam logic [1:0] REG_SPARE = 2'd3;

endpackage

>>> tb/asrf_fifo_checker.sv
module asrf_fifo_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [asrf_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample_in
	input  logic                               s_axis_tuser,  // [0] operation
	input  logic                               s_axis_tlast,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] sample_out, [25:16] fill_count, [54:26] ratio_now, [55] zero
	input  logic [asrf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               m_axis_tuser,  // [0] done_res
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [asrf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [asrf_pkg::MARK_W-1:0]        cfg_data,
	output int                                 mismatches,
	output int                                 backlog
);
	import asrf_pkg::*;
	import asrf_tb_pkg::*;

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] smp;
		logic [FILL_W-1:0]   fill;
		logic [RATIO_W-1:0]  ratio;
	} reply_t;

	reply_t              replies[$];
	logic [SAMPLE_W-1:0] store [1024];
	logic [FILL_W-1:0]   wr_ptr;
	logic [FILL_W-1:0]   rd_ptr;
	logic [PHASE_W-1:0]  phase;
	logic [RATIO_W-1:0]  ratio;
	smp_mode_t           mode;
	logic [MARK_W-1:0]   low_mark;
	logic [MARK_W-1:0]   high_mark;
	int                  fault_count;

	function automatic int entry_val(input logic [FILL_W-1:0] idx);
		logic [SAMPLE_W-1:0] raw;
		int v;
		raw = store[idx];
		if (mode == MODE_BYTE) begin
			v = raw[7:0];
		end else begin
			v = $signed(raw);
		end
		return v;
	endfunction

	task automatic resample_step(input op_t op, input logic [SAMPLE_W-1:0] smp,
			input logic last, output reply_t r);
		logic [FILL_W-1:0] held;
		logic [FILL_W-1:0] rd;
		logic [IPART_W-1:0] ipart;
		logic [FRAC_W-1:0] frac;
		logic [RATIO_W:0] adj;
		int a;
		int b;
		longint d;
		longint f;
		longint v;
		r = '0;
		held = wr_ptr - rd_ptr;
		if (op == OP_WRITE) begin
			if (held != '1) begin
				store[wr_ptr] = (mode == MODE_BYTE) ? {8'h00, smp[7:0]} : smp;
				wr_ptr = wr_ptr + 1'b1;
				r.done = 1'b1;
			end
			held = wr_ptr - rd_ptr;
			if (last && held > high_mark) begin
				adj = {1'b0, ratio} + (RATIO_W+1)'(ratio / 200);
				ratio = (adj > RATIO_MAX) ? RATIO_MAX : adj[RATIO_W-1:0];
			end
		end else begin
			ipart = phase[PHASE_W-1:FRAC_W];
			frac = phase[FRAC_W-1:0];
			rd = rd_ptr + ipart;
			if (held >= ipart + 2) begin
				a = entry_val(rd);
				b = entry_val(rd + 1'b1);
				d = b - a;
				f = frac;
				// The arithmetic shift of the signed product gives the floored quotient.
				v = a + ((d * f) >>> FRAC_W);
				r.smp = (mode == MODE_BYTE) ? {8'h00, v[7:0]} : v[15:0];
				rd_ptr = rd;
				phase = frac + ratio;
				r.done = 1'b1;
			end
			held = wr_ptr - rd_ptr;
			if (last && held < low_mark) begin
				adj = {1'b0, ratio} - (RATIO_W+1)'(ratio / 200);
				ratio = (adj < RATIO_MIN) ? RATIO_MIN : adj[RATIO_W-1:0];
			end
		end
		r.fill = held;
		r.ratio = ratio;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			wr_ptr = '0;
			rd_ptr = '0;
			phase = '0;
			ratio = RATIO_ONE;
			mode = MODE_WORD;
			low_mark = LOW_MARK_RST;
			high_mark = HIGH_MARK_RST;
			fault_count = 0;
			replies.delete();
			mismatches <= 0;
			backlog <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.done = m_axis_tuser;
				got.smp = m_axis_tdata[15:0];
				got.fill = m_axis_tdata[25:16];
				got.ratio = m_axis_tdata[54:26];
				if (replies.size() == 0) begin
					$error("result transaction arrived with no result expected");
					fault_count++;
				end else begin
					want = replies.pop_front();
					check_field("done_res", want.done, got.done);
					check_field("sample_out", want.smp, got.smp);
					check_field("fill_count", want.fill, got.fill);
					check_field("ratio_now", want.ratio, got.ratio);
					check_field("tdata pad", 32'd0, m_axis_tdata[55]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_MODE: mode = smp_mode_t'(cfg_data[0]);
					REG_LOW_MARK:    low_mark = cfg_data;
					REG_HIGH_MARK:   high_mark = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				resample_step(op_t'(s_axis_tuser), s_axis_tdata, s_axis_tlast, want);
				replies.push_back(want);
			end
			mismatches <= fault_count;
			backlog <= replies.size();
		end
	end

endmodule

>>> tb/tb_adaptive_resampling_sample_fifo_unit.sv
module tb_adaptive_resampling_sample_fifo_unit;
	import asrf_pkg::*;
	import asrf_tb_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [SAMPLE_W-1:0]      s_axis_tdata = '0;
	logic                     s_axis_tuser = 1'b0;
	logic                     s_axis_tlast = 1'b0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     m_axis_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [MARK_W-1:0]        cfg_data = '0;
	int                       mismatches;
	int                       backlog;
	int                       quiet_cycles = 0;
	int                       stall_left = 0;
	logic                     calm = 1'b0;

	adaptive_resampling_sample_fifo_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	asrf_fifo_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.backlog       (backlog)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		v = SAMPLE_W'($urandom);
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = v[0] ? 16'hFFFF : 16'h0000;
			3: v = SAMPLE_W'($urandom_range(0, 15) - 8);
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_item(input op_t op, input logic [SAMPLE_W-1:0] smp, input logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= smp;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Batches of one operation closed by last, with stray operations and
	// misplaced batch ends mixed in.
	task automatic run_traffic(input int count, input int write_pct, input int stray_pct);
		int sent;
		int len;
		op_t op;
		op_t item_op;
		logic last;
		sent = 0;
		while (sent < count) begin
			op = ($urandom_range(1, 100) <= write_pct) ? OP_WRITE : OP_READ;
			len = $urandom_range(1, 12);
			for (int j = 0; j < len && sent < count; j++) begin
				item_op = op;
				if ($urandom_range(1, 100) <= stray_pct) begin
					item_op = (op == OP_WRITE) ? OP_READ : OP_WRITE;
				end
				last = (j == len - 1);
				if ($urandom_range(1, 100) <= stray_pct) begin
					last = !last;
				end
				send_item(item_op, pick_sample(), last);
				sent++;
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MARK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input smp_mode_t mode, input logic [MARK_W-1:0] low,
			input logic [MARK_W-1:0] high);
		logic [MARK_W-2:0] junk;
		logic [MARK_W-1:0] spare;
		junk = (MARK_W-1)'($urandom);
		spare = MARK_W'($urandom);
		put_reg(REG_SPARE, spare);
		put_reg(REG_SAMPLE_MODE, {junk, mode});
		put_reg(REG_LOW_MARK, low);
		put_reg(REG_HIGH_MARK, high);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(OP_READ, pick_sample(), 1'b0);
		send_item(OP_WRITE, 16'h8000, 1'b0);
		send_item(OP_WRITE, 16'h7FFF, 1'b0);
		send_item(OP_WRITE, 16'h0000, 1'b0);
		send_item(OP_WRITE, 16'hFFFF, 1'b0);
		send_item(OP_WRITE, 16'h1234, 1'b0);
		send_item(OP_WRITE, 16'h00FF, 1'b1);
		send_item(OP_READ, pick_sample(), 1'b1);
		repeat (7) send_item(OP_READ, pick_sample(), 1'b0);
		send_item(OP_WRITE, 16'hA5A5, 1'b1);
		send_item(OP_WRITE, 16'h5A5A, 1'b0);
		s_axis_tvalid <= 1'b0;
		drain();

		program_regs(MODE_BYTE, 11'd256, 11'd768);
		send_item(OP_READ, pick_sample(), 1'b0);
		send_item(OP_WRITE, 16'h00FF, 1'b0);
		send_item(OP_WRITE, 16'hFF80, 1'b0);
		send_item(OP_WRITE, 16'h1200, 1'b1);
		send_item(OP_READ, pick_sample(), 1'b1);
		send_item(OP_READ, pick_sample(), 1'b1);
		send_item(OP_READ, pick_sample(), 1'b0);
		s_axis_tvalid <= 1'b0;
		drain();

		program_regs(MODE_WORD, 11'd1024, 11'd0);
		run_traffic(250, 60, 8);
		drain();

		program_regs(MODE_BYTE, 11'd0, 11'd1000);
		run_traffic(1050, 100, 2);
		drain();

		program_regs(MODE_WORD, 11'd900, 11'd2047);
		run_traffic(300, 10, 8);
		drain();

		program_regs(MODE_BYTE, 11'd512, 11'd300);
		run_traffic(50, 50, 8);
		calm <= 1'b1;
		run_traffic(150, 50, 8);
		drain();

		repeat (12) @(posedge clk);
		if (mismatches == 0 && backlog == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
